### sv/sdb_pkg.sv
package sdb_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_W = 16;
   localparam int SCALE_W = 16;
   localparam int PD_W    = 25;
   localparam int SD_W    = 32;
   localparam int BRG_W   = 17;

   // Internal widths.
   localparam int RAD_W   = 49;   // radicand (dx^2 + dy^2) << 16
   localparam int CV_W    = 28;   // CORDIC vector components
   localparam int CZ_W    = 27;   // CORDIC angle, 1/65536 degree
   localparam int REM_W   = 16;   // divider remainder

   // Arctangent table depth and default stage count.
   localparam int ATAN_ENTRIES       = 24;
   localparam int CORDIC_STAGES_DEF  = 16;

   // Register reset values and indexes.
   localparam logic [SCALE_W-1:0] MAP_SCALE_RST   = 16'd225;
   localparam logic [SCALE_W-1:0] PIXEL_SCALE_RST = 16'd100;
   localparam logic CSR_MAP_SCALE   = 1'b0;
   localparam logic CSR_PIXEL_SCALE = 1'b1;

   // Angles.
   localparam logic signed [CZ_W-1:0] HALF_TURN_Q16 = 27'sd11796480;
   localparam logic signed [CZ_W:0]   FULL_TURN_Q16 = 28'sd23592960;
   localparam logic [BRG_W:0]         FULL_TURN_Q8  = 18'd92160;
   localparam logic [BRG_W-1:0] BRG_NORTH = 17'd0;
   localparam logic [BRG_W-1:0] BRG_EAST  = 17'd23040;
   localparam logic [BRG_W-1:0] BRG_SOUTH = 17'd46080;
   localparam logic [BRG_W-1:0] BRG_WEST  = 17'd69120;

   // Square root cell state.
   typedef struct packed {
      logic [RAD_W-1:0] rem;
      logic [PD_W-1:0]  root;
   } sq_type;

   // CORDIC cell state.
   typedef struct packed {
      logic signed [CV_W-1:0] u;
      logic signed [CV_W-1:0] v;
      logic signed [CZ_W-1:0] z;
      logic                   special;
      logic [BRG_W-1:0]       spec_brg;
      logic                   same;
   } cor_type;

   // Divider cell state.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [SD_W-1:0]  dvd;
      logic [SD_W-1:0]  quot;
      logic             sat;
      logic [PD_W-1:0]  pd;
   } div_type;

   // Finished bearing on its way to the output.
   typedef struct packed {
      logic [BRG_W-1:0] bearing;
      logic             same;
   } brg_type;

   // atan(2^-i) in 1/65536 degree, rounded.
   function automatic logic signed [CZ_W-1:0] atan_q16(input int i);
      logic signed [CZ_W-1:0] r;
      case (i)
         0:  r = 27'sd2949120;
         1:  r = 27'sd1740967;
         2:  r = 27'sd919879;
         3:  r = 27'sd466945;
         4:  r = 27'sd234379;
         5:  r = 27'sd117304;
         6:  r = 27'sd58666;
         7:  r = 27'sd29335;
         8:  r = 27'sd14668;
         9:  r = 27'sd7334;
         10: r = 27'sd3667;
         11: r = 27'sd1833;
         12: r = 27'sd917;
         13: r = 27'sd458;
         14: r = 27'sd229;
         15: r = 27'sd115;
         16: r = 27'sd57;
         17: r = 27'sd29;
         18: r = 27'sd14;
         19: r = 27'sd7;
         20: r = 27'sd4;
         21: r = 27'sd2;
         22: r = 27'sd1;
         default: r = 27'sd0;
      endcase
      return r;
   endfunction

endpackage

### sv/sdb_sqrt_cell.sv
module sdb_sqrt_cell #(
   parameter int BIT = 24
) (
   input  logic           clock,
   input  sdb_pkg::sq_type cell_in,
   output sdb_pkg::sq_type cell_out
);
   import sdb_pkg::*;

   localparam int T_W = RAD_W + 2;

   sq_type data_ff, data_in;
   logic [T_W-1:0] trial;

   // Try to set this root bit: subtract (2*root + 2^BIT) * 2^BIT.
   always_comb begin
      trial = (T_W'(cell_in.root) << (BIT + 1)) + (T_W'(1) << (2 * BIT));
      data_in = cell_in;
      if (T_W'(cell_in.rem) >= trial) begin
         data_in.rem  = cell_in.rem - trial[RAD_W-1:0];
         data_in.root = cell_in.root | (PD_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_out = data_ff;

endmodule

### sv/sdb_cordic_cell.sv
module sdb_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  sdb_pkg::cor_type cell_in,
   output sdb_pkg::cor_type cell_out
);
   import sdb_pkg::*;

   cor_type data_ff, data_in;
   logic signed [CV_W-1:0] us, vs;

   // One vectoring rotation toward the up axis.
   always_comb begin
      us = cell_in.u >>> STAGE;
      vs = cell_in.v >>> STAGE;
      data_in = cell_in;
      if (!cell_in.v[CV_W-1]) begin
         data_in.u = cell_in.u + vs;
         data_in.v = cell_in.v - us;
         data_in.z = cell_in.z + atan_q16(STAGE);
      end else begin
         data_in.u = cell_in.u - vs;
         data_in.v = cell_in.v + us;
         data_in.z = cell_in.z - atan_q16(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_out = data_ff;

endmodule

### sv/sdb_div_cell.sv
module sdb_div_cell #(
   parameter int BIT = 31
) (
   input  logic                         clock,
   input  logic [sdb_pkg::SCALE_W-1:0]  divisor,
   input  sdb_pkg::div_type             cell_in,
   output sdb_pkg::div_type             cell_out
);
   import sdb_pkg::*;

   div_type data_ff, data_in;
   logic [REM_W:0] trial;

   // One restoring division step: bring down a dividend bit and subtract.
   always_comb begin
      trial = {cell_in.rem, cell_in.dvd[BIT]};
      data_in = cell_in;
      if (trial >= {1'b0, divisor}) begin
         data_in.rem  = REM_W'(trial - {1'b0, divisor});
         data_in.quot = cell_in.quot | (SD_W'(1) << BIT);
      end else begin
         data_in.rem  = trial[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_out = data_ff;

endmodule

### sv/scaled_distance_and_bearing_unit.sv
// Channel   Ports                          Handshake
// input     start, busy, req_*             taken when start is high and busy low
// result    rsp_valid, rsp_*               one-cycle strobe, no back-pressure
// config    csr_we, csr_index, csr_wdata   written when csr_we is high
//
// One item is taken every cycle; busy is always low.
// The distance path runs through the 25-cell square root chain and then the 32-cell divider chain;
// the CORDIC chain runs alongside, and its bearing is delayed to match the distance path.
// Reset is synchronous and restores the scale registers.
// The receiver cannot stall, so the chains advance every cycle.
module scaled_distance_and_bearing_unit #(
   parameter int CORDIC_STAGES = sdb_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sdb_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [sdb_pkg::COORD_W-1:0]  req_target_y,
   input  logic signed [sdb_pkg::COORD_W-1:0]  req_origin_x,
   input  logic signed [sdb_pkg::COORD_W-1:0]  req_origin_y,
   output logic                                rsp_valid,
   output logic [sdb_pkg::PD_W-1:0]            rsp_pixel_distance,
   output logic [sdb_pkg::SD_W-1:0]            rsp_scaled_distance,
   output logic [sdb_pkg::BRG_W-1:0]           rsp_bearing,
   output logic                                rsp_same_point,
   output logic                                rsp_scale_error,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [sdb_pkg::SCALE_W-1:0]         csr_wdata
);
   import sdb_pkg::*;

   localparam int NSTG    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   localparam int SQ_N    = PD_W;
   localparam int DIV_N   = SD_W;
   localparam int LAST    = 3 + SQ_N + 1 + DIV_N;   // stage of the last divider cell
   localparam int BRG_DLY = LAST - (3 + NSTG);

   logic [SCALE_W-1:0] map_scale_ff, pixel_scale_ff;
   logic [LAST-1:0]    vpipe_ff;
   logic               accept;

   logic signed [COORD_W:0] dx_ff, dy_ff;
   logic [2*COORD_W:0]      dxsq_ff, dysq_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [PD_W+SCALE_W-1:0] prod_ff;
   logic [PD_W-1:0]         pd_ff;

   sq_type  sq_chain  [0:SQ_N];
   cor_type cor_chain [0:NSTG];
   div_type div_chain [0:DIV_N];
   cor_type cor_init_ff, cor_init_in;
   brg_type brg_ff, brg_in;
   brg_type brg_dly_ff [0:BRG_DLY-1];

   logic signed [2*COORD_W+1:0] dxsq_full, dysq_full;
   logic signed [CZ_W:0]        zwrap;
   logic [BRG_W:0]              rnd;
   logic                        sat;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Scale registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_scale_ff   <= MAP_SCALE_RST;
         pixel_scale_ff <= PIXEL_SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_SCALE:   map_scale_ff   <= csr_wdata;
            CSR_PIXEL_SCALE: pixel_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits follow each item down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         vpipe_ff  <= {vpipe_ff[LAST-2:0], accept};
         rsp_valid <= vpipe_ff[LAST-1];
      end
   end

   // Differences, squares and the radicand.
   assign dxsq_full = dx_ff * dx_ff;
   assign dysq_full = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      dx_ff   <= (COORD_W+1)'(req_target_x) - (COORD_W+1)'(req_origin_x);
      dy_ff   <= (COORD_W+1)'(req_target_y) - (COORD_W+1)'(req_origin_y);
      dxsq_ff <= dxsq_full[2*COORD_W:0];
      dysq_ff <= dysq_full[2*COORD_W:0];
      rad_ff  <= {(RAD_W-16)'(dxsq_ff) + (RAD_W-16)'(dysq_ff), 16'd0};
   end

   // Square root chain, one root bit per cell from the top.
   assign sq_chain[0] = '{rem: rad_ff, root: '0};

   for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
      sdb_sqrt_cell #(.BIT(SQ_N - 1 - g)) u_cell (
         .clock    (clock),
         .cell_in  (sq_chain[g]),
         .cell_out (sq_chain[g+1])
      );
   end

   // Distance times map scale.
   always_ff @(posedge clock) begin
      prod_ff <= (PD_W+SCALE_W)'(sq_chain[SQ_N].root) * (PD_W+SCALE_W)'(map_scale_ff);
      pd_ff   <= sq_chain[SQ_N].root;
   end

   // The quotient overflows 32 bits when the top of the product reaches the divisor, or the divisor is zero.
   always_comb begin
      sat = (pixel_scale_ff == '0) ||
            (SCALE_W'(prod_ff[PD_W+SCALE_W-1:SD_W]) >= pixel_scale_ff);
      div_chain[0].rem  = sat ? '0 : SCALE_W'(prod_ff[PD_W+SCALE_W-1:SD_W]);
      div_chain[0].dvd  = prod_ff[SD_W-1:0];
      div_chain[0].quot = '0;
      div_chain[0].sat  = sat;
      div_chain[0].pd   = pd_ff;
   end

   for (genvar g = 0; g < DIV_N; g++) begin : g_div
      sdb_div_cell #(.BIT(DIV_N - 1 - g)) u_cell (
         .clock    (clock),
         .divisor  (pixel_scale_ff),
         .cell_in  (div_chain[g]),
         .cell_out (div_chain[g+1])
      );
   end

   // CORDIC start: turn a downward vector by a half turn, flag axis cases.
   always_comb begin
      cor_init_in.same     = (dx_ff == '0) && (dy_ff == '0);
      cor_init_in.special  = 1'b1;
      cor_init_in.spec_brg = BRG_NORTH;
      if (cor_init_in.same) begin
         cor_init_in.spec_brg = BRG_NORTH;
      end else if (dx_ff == '0) begin
         cor_init_in.spec_brg = dy_ff[COORD_W] ? BRG_NORTH : BRG_SOUTH;
      end else if (dy_ff == '0) begin
         cor_init_in.spec_brg = dx_ff[COORD_W] ? BRG_WEST : BRG_EAST;
      end else begin
         cor_init_in.special = 1'b0;
      end
      if (!dy_ff[COORD_W]) begin
         cor_init_in.u = CV_W'(dy_ff) <<< 8;
         cor_init_in.v = -(CV_W'(dx_ff) <<< 8);
         cor_init_in.z = HALF_TURN_Q16;
      end else begin
         cor_init_in.u = -(CV_W'(dy_ff) <<< 8);
         cor_init_in.v = CV_W'(dx_ff) <<< 8;
         cor_init_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      cor_init_ff <= cor_init_in;
   end

   assign cor_chain[0] = cor_init_ff;

   for (genvar g = 0; g < NSTG; g++) begin : g_cordic
      sdb_cordic_cell #(.STAGE(g)) u_cell (
         .clock    (clock),
         .cell_in  (cor_chain[g]),
         .cell_out (cor_chain[g+1])
      );
   end

   // Wrap the angle into one turn and round to 1/256 degree.
   always_comb begin
      zwrap = (CZ_W+1)'(cor_chain[NSTG].z);
      if (cor_chain[NSTG].z[CZ_W-1]) begin
         zwrap = zwrap + FULL_TURN_Q16;
      end
      rnd = (BRG_W+1)'((zwrap + (CZ_W+1)'(128)) >>> 8);
      if (rnd >= FULL_TURN_Q8) begin
         rnd = rnd - FULL_TURN_Q8;
      end
      brg_in.same    = cor_chain[NSTG].same;
      brg_in.bearing = cor_chain[NSTG].special ? cor_chain[NSTG].spec_brg : rnd[BRG_W-1:0];
   end

   // Bearing waits for the distance path.
   always_ff @(posedge clock) begin
      brg_ff        <= brg_in;
      brg_dly_ff[0] <= brg_ff;
      for (int i = 1; i < BRG_DLY; i++) begin
         brg_dly_ff[i] <= brg_dly_ff[i-1];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (vpipe_ff[LAST-1]) begin
         rsp_pixel_distance  <= div_chain[DIV_N].pd;
         rsp_scaled_distance <= div_chain[DIV_N].sat ? '1 : div_chain[DIV_N].quot;
         rsp_bearing         <= brg_dly_ff[BRG_DLY-1].bearing;
         rsp_same_point      <= brg_dly_ff[BRG_DLY-1].same;
         rsp_scale_error     <= (pixel_scale_ff == '0);
      end
   end

endmodule
